@@ design/irs_pkg.sv @@
// shared types and constants for the index ranking sorter
package irs_pkg;

   localparam int MAX_SAMPLES  = 64;
   localparam int SAMPLE_WIDTH = 32;
   localparam int IDX_W        = $clog2(MAX_SAMPLES);
   localparam int CNT_W        = $clog2(MAX_SAMPLES + 1);
   localparam int SRC_W        = 6;

   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam logic CSR_REG_ASCENDING = 1'b0;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SORT,
      ST_EMIT
   } irs_state_type;

   typedef struct packed {
      logic load;   // store the request sample
      logic close;  // request flagged last: latch set size, clear sorter cells
      logic rd;     // read next stored sample into the insert stage
      logic pop;    // result taken: shift the sorted row down
   } irs_cmd_type;

   typedef struct packed {
      logic rd_done;   // all stored samples have been read
      logic ins_busy;  // a sample is still waiting to be inserted
      logic last_out;  // result on the head cell is the final one
   } irs_status_type;

endpackage

@@ design/irs_ctrl.sv @@
// controller state machine: load, sort and emit phases
module irs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tlast,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output irs_pkg::irs_cmd_type    cmd,
   input  irs_pkg::irs_status_type status
);
   import irs_pkg::*;

   irs_state_type state_ff;
   irs_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_tlast) begin
                  cmd.close = 1'b1;
                  state_in  = ST_SORT;
               end
            end
         end
         ST_SORT: begin
            if (!status.rd_done) begin
               cmd.rd = 1'b1;
            end else if (!status.ins_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               cmd.pop = 1'b1;
               if (status.last_out) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

@@ design/irs_dpath.sv @@
// datapath: sample memory, insertion row of sorter cells, counters
module irs_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic signed [irs_pkg::SAMPLE_WIDTH-1:0] sample_value,
   input  logic                                 ascending_order,
   input  irs_pkg::irs_cmd_type                 cmd,
   output irs_pkg::irs_status_type              status,
   output logic [irs_pkg::SRC_W-1:0]            source_index
);
   import irs_pkg::*;

   logic signed [SAMPLE_WIDTH-1:0] mem [MAX_SAMPLES];

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic             ins_vld_ff;
   logic signed [SAMPLE_WIDTH-1:0] rd_data_ff;
   logic [IDX_W-1:0] rd_idx_ff;

   logic signed [SAMPLE_WIDTH-1:0] key_ff [MAX_SAMPLES];
   logic signed [SAMPLE_WIDTH-1:0] key_in [MAX_SAMPLES];
   logic [IDX_W-1:0] idx_ff [MAX_SAMPLES];
   logic [IDX_W-1:0] idx_in [MAX_SAMPLES];
   logic [MAX_SAMPLES-1:0] vld_ff, vld_in;

   logic [MAX_SAMPLES-1:0] gt;        // cell must follow the incoming sample
   logic [MAX_SAMPLES-1:0] prev_gt;
   logic [MAX_SAMPLES-1:0] prev_vld;
   logic signed [SAMPLE_WIDTH-1:0] prev_key [MAX_SAMPLES];
   logic [IDX_W-1:0] prev_idx [MAX_SAMPLES];
   logic signed [SAMPLE_WIDTH-1:0] next_key [MAX_SAMPLES];
   logic [IDX_W-1:0] next_idx [MAX_SAMPLES];
   logic [MAX_SAMPLES-1:0] next_vld;

   logic full;

   assign full = (count_ff == CNT_W'(MAX_SAMPLES));

   always_ff @(posedge clock) begin
      if (cmd.load && !full) begin
         mem[count_ff[IDX_W-1:0]] <= sample_value;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[rd_ff[IDX_W-1:0]];
         rd_idx_ff  <= rd_ff[IDX_W-1:0];
      end
   end

   always_comb begin
      count_in = count_ff;
      n_in     = n_ff;
      rd_in    = rd_ff;
      rem_in   = rem_ff;
      if (cmd.load && !full) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.close) begin
         n_in     = count_in;
         rem_in   = count_in;
         rd_in    = '0;
         count_in = '0;
      end
      if (cmd.rd) begin
         rd_in = rd_ff + 1'b1;
      end
      if (cmd.pop) begin
         rem_in = rem_ff - 1'b1;
      end
   end

   // neighbor views of the cell row
   always_comb begin
      for (int i = 0; i < MAX_SAMPLES; i++) begin
         if (ascending_order) begin
            gt[i] = vld_ff[i] && (key_ff[i] > rd_data_ff);
         end else begin
            gt[i] = vld_ff[i] && (key_ff[i] < rd_data_ff);
         end
      end
      prev_gt[0]  = 1'b0;
      prev_vld[0] = 1'b1;
      prev_key[0] = key_ff[0];
      prev_idx[0] = idx_ff[0];
      for (int i = 1; i < MAX_SAMPLES; i++) begin
         prev_gt[i]  = gt[i-1];
         prev_vld[i] = vld_ff[i-1];
         prev_key[i] = key_ff[i-1];
         prev_idx[i] = idx_ff[i-1];
      end
      for (int i = 0; i < MAX_SAMPLES - 1; i++) begin
         next_key[i] = key_ff[i+1];
         next_idx[i] = idx_ff[i+1];
         next_vld[i] = vld_ff[i+1];
      end
      next_key[MAX_SAMPLES-1] = key_ff[MAX_SAMPLES-1];
      next_idx[MAX_SAMPLES-1] = idx_ff[MAX_SAMPLES-1];
      next_vld[MAX_SAMPLES-1] = 1'b0;
   end

   // insert keeps the row sorted; equal keys stay behind earlier ones
   always_comb begin
      for (int i = 0; i < MAX_SAMPLES; i++) begin
         key_in[i] = key_ff[i];
         idx_in[i] = idx_ff[i];
         vld_in[i] = vld_ff[i];
         if (cmd.close) begin
            vld_in[i] = 1'b0;
         end else if (ins_vld_ff) begin
            if (prev_gt[i]) begin
               key_in[i] = prev_key[i];
               idx_in[i] = prev_idx[i];
               vld_in[i] = 1'b1;
            end else if ((gt[i] || !vld_ff[i]) && prev_vld[i]) begin
               key_in[i] = rd_data_ff;
               idx_in[i] = rd_idx_ff;
               vld_in[i] = 1'b1;
            end
         end else if (cmd.pop) begin
            key_in[i] = next_key[i];
            idx_in[i] = next_idx[i];
            vld_in[i] = next_vld[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         n_ff       <= '0;
         rd_ff      <= '0;
         rem_ff     <= '0;
         ins_vld_ff <= 1'b0;
         vld_ff     <= '0;
      end else begin
         count_ff   <= count_in;
         n_ff       <= n_in;
         rd_ff      <= rd_in;
         rem_ff     <= rem_in;
         ins_vld_ff <= cmd.rd;
         vld_ff     <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_SAMPLES; i++) begin
         key_ff[i] <= key_in[i];
         idx_ff[i] <= idx_in[i];
      end
   end

   assign status.rd_done  = (rd_ff == n_ff);
   assign status.ins_busy = ins_vld_ff;
   assign status.last_out = (rem_ff == CNT_W'(1));
   assign source_index    = SRC_W'(idx_ff[0]);

endmodule

@@ design/index_ranking_sorter_core.sv @@
// top level of the index ranking sorter: stream ports, register port, core wiring
//
// channel   direction  payload
// req_      in         tdata = sample_value[31:0]; tlast = last_sample
// rsp_      out        tdata = source_index[5:0], zeros[7:6]; tlast = last_rank
// csr_      in/out     ascending_order at byte address 0, bit 0
//
// loading accepts one request per cycle; the flagged request closes the set
// ranking reads the n stored samples from the sample memory one per cycle
// into a row of compare cells
// results then leave one per cycle from the head of the row while rsp_tready is high
// requests are held off from close of set until the final result is taken
// reset empties the set and sets ascending order
module index_ranking_sorter_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [31:0]                       req_tdata,   // sample_value[31:0]
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,   // source_index[5:0], zero[7:6]
   output logic                              rsp_tlast,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [irs_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [irs_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [irs_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import irs_pkg::*;

   logic           ascending_ff;
   irs_cmd_type    cmd;
   irs_status_type status;
   logic [SRC_W-1:0] source_index;
   logic           csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ascending_ff <= 1'b1;
      end else if (csr_wr && (csr_paddr[2] == CSR_REG_ASCENDING)) begin
         ascending_ff <= csr_pwdata[0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_REG_ASCENDING) begin
         csr_prdata[0] = ascending_ff;
      end
   end

   irs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   irs_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .sample_value    (req_tdata[SAMPLE_WIDTH-1:0]),
      .ascending_order (ascending_ff),
      .cmd             (cmd),
      .status          (status),
      .source_index    (source_index)
   );

   assign rsp_tdata = {2'b00, source_index};
   assign rsp_tlast = status.last_out;

endmodule

@@ tb/tb_index_ranking_sorter_core.sv @@
// testbench for index_ranking_sorter_core: stream and register stimulus, ranking predictor, checks
`timescale 1ns / 100ps

module tb_index_ranking_sorter_core;
   import irs_pkg::*;

   localparam int LIMIT_CYCLES = 400_000;
   localparam int SETTLE_CYCLES = 8;

   localparam logic [CSR_ADDR_W-1:0] ADDR_ORDER = CSR_ADDR_W'(4 * CSR_REG_ASCENDING);
   // no register decodes here
   localparam logic [CSR_ADDR_W-1:0] ADDR_SPARE = CSR_ADDR_W'(4);

   localparam logic [31:0] VAL_MIN = 32'h8000_0000;
   localparam logic [31:0] VAL_MAX = 32'h7fff_ffff;

   typedef enum logic [1:0] {
      ROW_SAMPLE,
      ROW_WRITE
   } row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic [31:0]               data;
      logic [CSR_ADDR_W-1:0]     addr;
      logic                      last;
      logic [2:0]                n_typed;
      logic [0:3][SRC_W-1:0]     typed_idx;
   } stim_row_type;

   typedef struct packed {
      logic [SRC_W-1:0] source_index;
      logic             last_rank;
   } rank_entry_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [31:0]             req_tdata = '0;   // sample_value[31:0]
   logic                    req_tlast = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [7:0]              rsp_tdata;        // source_index[5:0], zero[7:6]
   logic                    rsp_tlast;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   logic signed [31:0]      sample_mem [MAX_SAMPLES];
   int                      sample_count = 0;
   logic                    ascend_mode = 1'b1;
   rank_entry_type          pending_ranks [$];

   int                      errors = 0;
   int                      cycles = 0;
   int                      send_idle_pct = 0;
   int                      recv_idle_pct = 0;

   index_ranking_sorter_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("index_ranking_sorter_core regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      rank_entry_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_ranks.size() == 0) begin
            $error("source_index: expected none, actual %0d", rsp_tdata[SRC_W-1:0]);
            errors++;
         end else begin
            want = pending_ranks.pop_front();
            if (rsp_tdata[SRC_W-1:0] !== want.source_index) begin
               $error("source_index: expected %0d, actual %0d",
                      want.source_index, rsp_tdata[SRC_W-1:0]);
               errors++;
            end
            if (rsp_tlast !== want.last_rank) begin
               $error("last_rank: expected %0d, actual %0d", want.last_rank, rsp_tlast);
               errors++;
            end
         end
      end
   end

   function automatic bit out_of_order(logic signed [31:0] a, logic signed [31:0] b);
      return ascend_mode ? (a > b) : (a < b);
   endfunction

   // stable insertion sort of the stored set, strict compare keeps ties in load order
   task automatic rank_set();
      int order [MAX_SAMPLES];
      int i;
      int j;
      int cur;
      rank_entry_type e;
      for (i = 0; i < sample_count; i++) order[i] = i;
      for (i = 1; i < sample_count; i++) begin
         cur = order[i];
         j = i;
         while (j > 0 && out_of_order(sample_mem[order[j-1]], sample_mem[cur])) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = cur;
      end
      for (i = 0; i < sample_count; i++) begin
         e.source_index = SRC_W'(order[i]);
         e.last_rank = (i == sample_count - 1);
         pending_ranks.push_back(e);
      end
   endtask

   task automatic record_sample(logic [31:0] v, logic l, int n_typed,
                                logic [0:3][SRC_W-1:0] typed_idx);
      rank_entry_type e;
      // a full store drops the sample, flagged or not
      if (sample_count < MAX_SAMPLES) begin
         sample_mem[sample_count] = v;
         sample_count++;
      end
      if (l) begin
         if (n_typed > 0) begin
            for (int k = 0; k < n_typed; k++) begin
               e.source_index = typed_idx[k];
               e.last_rank = (k == n_typed - 1);
               pending_ranks.push_back(e);
            end
         end else begin
            rank_set();
         end
         sample_count = 0;
      end
   endtask

   task automatic send_sample(logic [31:0] v, logic l, int n_typed = 0,
                              logic [0:3][SRC_W-1:0] typed_idx = '0);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= v;
      req_tlast <= l;
      do @(posedge clock); while (!req_tready);
      record_sample(v, l, n_typed, typed_idx);
   endtask

   // drop valid, drain all ranks, then wait SETTLE_CYCLES so the block can return to load
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_ranks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_ORDER) ascend_mode = data[0];
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_readback();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= ADDR_ORDER;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(ascend_mode)) begin
         $error("ascending_order: expected %0d, actual %0d", ascend_mode, csr_prdata);
         errors++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic stim_row_type smp(logic [31:0] v, logic l, int n = 0,
                                        logic [0:3][SRC_W-1:0] idx = '0);
      stim_row_type r;
      r = '0;
      r.kind = ROW_SAMPLE;
      r.data = v;
      r.last = l;
      r.n_typed = 3'(n);
      r.typed_idx = idx;
      return r;
   endfunction

   function automatic stim_row_type wr(logic [CSR_ADDR_W-1:0] addr, logic [31:0] data);
      stim_row_type r;
      r = '0;
      r.kind = ROW_WRITE;
      r.addr = addr;
      r.data = data;
      return r;
   endfunction

   // small values are common so that ties show up
   function automatic logic [31:0] pick_sample();
      case ($urandom_range(9))
         0: return VAL_MIN;
         1: return VAL_MAX;
         2: return 32'hffff_ffff;
         3, 4, 5: return 32'(int'($urandom_range(6)) - 3);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      stim_row_type directed_rows [$];
      int set_len;
      int phase_items;
      int send_pct [3];
      int recv_pct [3];

      send_pct = '{22, 65, 0};
      recv_pct = '{65, 22, 0};

      directed_rows = '{
         smp(VAL_MIN, 1'b1, 1, {6'd0, 6'd0, 6'd0, 6'd0}),
         smp(VAL_MAX, 1'b1, 1, {6'd0, 6'd0, 6'd0, 6'd0}),
         smp(VAL_MAX, 1'b0),
         smp(VAL_MIN, 1'b1, 2, {6'd1, 6'd0, 6'd0, 6'd0}),
         smp(32'd0, 1'b0),
         smp(32'hffff_ffff, 1'b0),
         smp(32'd1, 1'b1, 3, {6'd1, 6'd0, 6'd2, 6'd0}),
         smp(32'd7, 1'b0),
         smp(32'd7, 1'b0),
         smp(32'd7, 1'b1, 3, {6'd0, 6'd1, 6'd2, 6'd0}),
         wr(ADDR_ORDER, 32'd0),
         smp(VAL_MAX, 1'b0),
         smp(VAL_MIN, 1'b1, 2, {6'd0, 6'd1, 6'd0, 6'd0}),
         smp(32'd3, 1'b0),
         smp(32'd3, 1'b0),
         smp(-32'sd3, 1'b1, 3, {6'd0, 6'd1, 6'd2, 6'd0}),
         wr(ADDR_SPARE, 32'd1),
         smp(32'd1, 1'b0),
         smp(32'd2, 1'b1, 2, {6'd1, 6'd0, 6'd0, 6'd0}),
         wr(ADDR_ORDER, 32'hffff_fffe),
         smp(-32'sd5, 1'b0),
         smp(32'd9, 1'b0),
         smp(-32'sd5, 1'b0),
         smp(32'd9, 1'b1),
         wr(ADDR_ORDER, 32'hffff_ffff),
         smp(VAL_MIN, 1'b0),
         smp(VAL_MIN, 1'b0),
         smp(VAL_MAX, 1'b1)
      };

      send_idle_pct = send_pct[0];
      recv_idle_pct = recv_pct[0];
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_readback();

      foreach (directed_rows[r]) begin
         case (directed_rows[r].kind)
            ROW_SAMPLE: begin
               send_sample(directed_rows[r].data, directed_rows[r].last,
                           directed_rows[r].n_typed, directed_rows[r].typed_idx);
            end
            ROW_WRITE: begin
               settle();
               csr_write(directed_rows[r].addr, directed_rows[r].data);
               csr_readback();
            end
            default: ;
         endcase
      end

      // overfilled set: the tail, flagged sample included, is dropped
      for (int k = 0; k < MAX_SAMPLES + 6; k++) send_sample(pick_sample(), k == MAX_SAMPLES + 5);

      for (int p = 0; p < 3; p++) begin
         settle();
         send_idle_pct = send_pct[p];
         recv_idle_pct = recv_pct[p];
         csr_write(ADDR_ORDER, {31'($urandom_range(32'h7fff_ffff)), 1'($urandom_range(1))});
         csr_readback();
         phase_items = 0;
         while (phase_items < 20) begin
            case ($urandom_range(99)) inside
               [0:84]:  set_len = $urandom_range(1, 8);
               [85:96]: set_len = $urandom_range(9, 24);
               default: set_len = $urandom_range(MAX_SAMPLES - 4, MAX_SAMPLES + 4);
            endcase
            if (phase_items > 0 && $urandom_range(5) == 0) begin
               settle();
               csr_write(ADDR_ORDER, {31'd0, 1'($urandom_range(1))});
            end
            for (int k = 0; k < set_len; k++) send_sample(pick_sample(), k == set_len - 1);
            phase_items += set_len;
         end
      end

      req_tvalid <= 1'b0;
      while (pending_ranks.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("index_ranking_sorter_core regression: pass");
      end else begin
         $display("index_ranking_sorter_core regression: fail");
      end
      $finish;
   end

endmodule
